### rtl/glli_pkg.sv
package glli_pkg;

  typedef struct packed {
    logic        mode;
    logic [7:0]  point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic        y_missing;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_result;
    logic        result_missing;
  } out_item_t;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_MAX_GAP     = 2'd1;
  localparam logic [1:0] REG_HOLD_ENDS   = 2'd2;

  localparam logic [8:0]  POINT_COUNT_RESET = 9'd2;
  localparam logic [16:0] MAX_GAP_RESET     = 17'd99999;

  // Control signals between the query sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

### rtl/glli_muldiv.sv
// Computes round(a*d/s) for a < 2^33, d < 2^32, 0 < s < 2^32, one quotient bit a cycle.
// Quotients at or above 2^41 are capped at 2^40, which still saturates downstream.
module glli_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] a_i,
  input  logic [31:0] d_i,
  input  logic [31:0] s_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [40:0] q_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} st_e;

  st_e         st_q;
  logic [64:0] num_q;
  logic [31:0] s_q;
  logic [32:0] a_q;
  logic [31:0] d_q;
  logic [32:0] rem_q;
  logic [40:0] q_q;
  logic [6:0]  cnt_q;
  logic        big_q;

  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q[31:0], num_q[64]};
  assign ge     = rem_sh >= {1'b0, s_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      big_q <= 1'b0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (start_i) begin
            a_q  <= a_i;
            d_q  <= d_i;
            s_q  <= s_i;
            st_q <= S_MUL;
          end
        end
        S_MUL: begin
          num_q <= 65'(a_q * {1'b0, d_q}) + 65'(s_q >> 1);
          rem_q <= '0;
          q_q   <= '0;
          big_q <= 1'b0;
          cnt_q <= 7'd65;
          st_q  <= S_DIV;
        end
        S_DIV: begin
          num_q <= {num_q[63:0], 1'b0};
          if (ge) begin
            rem_q <= rem_sh - {1'b0, s_q};
            if (cnt_q > 7'd41) big_q <= 1'b1;
          end else begin
            rem_q <= rem_sh;
          end
          q_q   <= {q_q[39:0], ge & (cnt_q <= 7'd41)};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) st_q <= S_DONE;
        end
        S_DONE: st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = st_q != S_IDLE;
  assign done_o = st_q == S_DONE;
  assign q_o    = big_q ? {1'b1, 40'd0} : q_q;

endmodule

### rtl/gap_limited_linear_interpolator.sv
// Load items are written into the table memory when accepted. A query takes a linear
// search over the table memory; each table entry visited takes a registered read of the
// table, then the compare, and a 65-step bit-serial divider computes the interpolated
// value. One item at a time.
// Reset is asynchronous and clears control and the configuration registers
// (point_count 2, max_gap 99999, hold_ends 0); the table is undefined until loaded.
module gap_limited_linear_interpolator #(
  parameter int MAX_POINTS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  glli_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output glli_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = AW + 1;

  // One memory holds x, y and the missing flag of every point.
  logic [64:0] table_mem [MAX_POINTS];
  logic [64:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  logic [8:0]  point_count_q;
  logic [16:0] max_gap_q;
  logic        hold_ends_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= glli_pkg::POINT_COUNT_RESET;
      max_gap_q     <= glli_pkg::MAX_GAP_RESET;
      hold_ends_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        glli_pkg::REG_POINT_COUNT: point_count_q <= cfg_data_i[8:0];
        glli_pkg::REG_MAX_GAP:     max_gap_q     <= cfg_data_i[16:0];
        glli_pkg::REG_HOLD_ENDS:   hold_ends_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective count, clamped to 2..MAX_POINTS.
  logic [CW-1:0] n_eff;
  always_comb begin
    if (point_count_q < 9'd2) n_eff = CW'(2);
    else if (32'(point_count_q) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
    else n_eff = CW'(point_count_q);
  end

  typedef enum logic [3:0] {
    S_IDLE, S_RD_FIRST, S_CHK_FIRST, S_CHK_LAST, S_SEARCH, S_WALK_L, S_WALK_R,
    S_CHECK, S_DIV_WAIT, S_OUT
  } st_e;

  st_e st_q;
  logic signed [31:0] xq_q;
  logic [CW-1:0] idx_q, left_q, right_q, iref_q;
  logic signed [31:0] xl_q, yl_q;
  logic               neg_q;
  glli_pkg::out_item_t out_q;
  logic               div_start_q;
  logic               div_busy;
  logic               div_done;

  logic [32:0] div_a;
  logic [31:0] div_d, div_s;
  logic [40:0] div_q;
  logic [32:0] div_a_q;
  logic [31:0] div_d_q, div_s_q;

  logic signed [31:0] rx, ry;
  logic               rm;
  assign rx = rd_q[64:33];
  assign ry = rd_q[32:1];
  assign rm = rd_q[0];

  logic in_acc;
  assign in_stall_o = (st_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Address for the next memory read, set by the sequencer.
  logic [CW-1:0] raddr_c;
  assign rd_addr = raddr_c[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc && in_item_i.mode == glli_pkg::MODE_LOAD &&
        32'(in_item_i.point_index) < MAX_POINTS) begin
      table_mem[AW'(in_item_i.point_index)] <=
        {in_item_i.x_value, in_item_i.y_value, in_item_i.y_missing};
    end
    if (rd_en) rd_q <= table_mem[rd_addr];
  end

  // Span checks on the neighbours once both are read.
  logic signed [32:0] span;
  logic [33:0]        gap_lim;
  logic signed [32:0] dy;
  logic signed [32:0] dx;
  assign span    = 33'(rx) - 33'(xl_q);
  assign gap_lim = {18'(max_gap_q) + 18'd1, 16'd0};
  assign dy      = 33'(ry) - 33'(yl_q);
  assign dx      = 33'(xq_q) - 33'(xl_q);

  // Result assembly with saturation.
  logic signed [42:0] res;
  logic signed [31:0] res_sat;
  assign res = neg_q ? 43'(yl_q) - 43'(div_q) : 43'(yl_q) + 43'(div_q);
  always_comb begin
    if (res > 43'sh7FFFFFFF) res_sat = 32'sh7FFFFFFF;
    else if (res < -43'sh80000000) res_sat = 32'sh80000000;
    else res_sat = res[31:0];
  end

  always_comb begin
    rd_en   = 1'b1;
    raddr_c = idx_q;
    case (st_q)
      S_IDLE:   raddr_c = '0;
      S_WALK_L: raddr_c = left_q;
      S_WALK_R: raddr_c = right_q;
      default:  raddr_c = idx_q;
    endcase
  end

  assign div_a = div_a_q;
  assign div_d = div_d_q;
  assign div_s = div_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      div_start_q <= 1'b0;
      out_q       <= '0;
    end else begin
      div_start_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (in_acc && in_item_i.mode == glli_pkg::MODE_QUERY) begin
            xq_q  <= in_item_i.x_value;
            idx_q <= n_eff - CW'(1);
            st_q  <= S_RD_FIRST;
          end
        end
        S_RD_FIRST: begin
          // Entry 0 read is in rd_q; last entry read is being issued.
          if (xq_q < rx) begin
            out_q <= hold_ends_q
                     ? glli_pkg::out_item_t'{y_result: rm ? 32'sd0 : ry, result_missing: rm}
                     : glli_pkg::out_item_t'{y_result: 32'sd0, result_missing: 1'b1};
            st_q  <= S_OUT;
          end else begin
            st_q <= S_CHK_LAST;
          end
        end
        S_CHK_LAST: begin
          if (xq_q >= rx) begin
            if (hold_ends_q || xq_q == rx)
              out_q <= '{y_result: rm ? 32'sd0 : ry, result_missing: rm};
            else
              out_q <= '{y_result: 32'sd0, result_missing: 1'b1};
            st_q <= S_OUT;
          end else begin
            idx_q <= CW'(1);
            st_q  <= S_CHK_FIRST;
          end
        end
        S_CHK_FIRST: st_q <= S_SEARCH; // read of entry idx_q in flight
        S_SEARCH: begin
          if (rx > xq_q) begin
            iref_q <= idx_q;
            left_q <= idx_q - CW'(1);
            st_q   <= S_WALK_L;
          end else begin
            idx_q <= idx_q + CW'(1);
            st_q  <= S_CHK_FIRST;
          end
        end
        S_WALK_L: begin
          // Issue read of left_q, evaluate next cycle.
          idx_q <= left_q;
          st_q  <= S_CHECK;
          right_q <= CW'(0);
        end
        S_CHECK: begin
          if (right_q == CW'(0)) begin
            // Evaluating a left candidate.
            if (rm && left_q != CW'(0)) begin
              left_q <= left_q - CW'(1);
              st_q   <= S_WALK_L;
            end else if (rm) begin
              out_q <= '{y_result: 32'sd0, result_missing: 1'b1};
              st_q  <= S_OUT;
            end else begin
              xl_q    <= rx;
              yl_q    <= ry;
              right_q <= iref_q;
              idx_q   <= iref_q;
              st_q    <= S_WALK_R;
            end
          end else if (!div_busy && !div_done) begin
            // Evaluating a right candidate.
            if (rm) begin
              if (right_q + CW'(1) >= n_eff) begin
                out_q <= '{y_result: 32'sd0, result_missing: 1'b1};
                st_q  <= S_OUT;
              end else begin
                right_q <= right_q + CW'(1);
                idx_q   <= right_q + CW'(1);
                st_q    <= S_WALK_R;
              end
            end else if (span <= 33'sd0 || 34'(span) > gap_lim) begin
              out_q <= '{y_result: 32'sd0, result_missing: 1'b1};
              st_q  <= S_OUT;
            end else begin
              neg_q       <= dy < 0;
              div_a_q     <= dy < 0 ? 33'(-dy) : 33'(dy);
              div_d_q     <= dx[31:0];
              div_s_q     <= span[31:0];
              div_start_q <= 1'b1;
              st_q        <= S_DIV_WAIT;
            end
          end
        end
        S_WALK_R: st_q <= S_CHECK;
        S_DIV_WAIT: begin
          if (div_done) begin
            out_q <= '{y_result: res_sat, result_missing: 1'b0};
            st_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  glli_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .a_i    (div_a),
    .d_i    (div_d),
    .s_i    (div_s),
    .busy_o (div_busy),
    .done_o (div_done),
    .q_o    (div_q)
  );

  assign out_valid_o = (st_q == S_OUT);
  assign out_item_o  = out_q;

  // A missing result always carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_missing |-> out_item_o.y_result == 32'sd0)
    else $error("missing result with nonzero value");

  // The divider is only started from the neighbour check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> $past(st_q) == S_CHECK)
    else $error("divider started out of sequence");

  // No new item enters while a query is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> in_stall_o)
    else $error("input taken while busy");

endmodule
